/* rtl/iss_pkg.sv */
// Shared types and constants for the indexed sequence store.
// Holds field widths, operation and status codes, request/result structs
// and the command that the controller broadcasts to the cell row.
`timescale 1ns / 1ps

package iss_pkg;

  localparam int DATA_W    = 32;
  localparam int OP_W      = 4;
  localparam int POS_W     = 5;
  localparam int AMT_W     = 5;
  localparam int LEN_W     = 5;
  localparam int ST_W      = 2;
  localparam int DEPTH_DEF = 16;
  // Widest cell index for the supported depth range (up to 256 cells).
  localparam int CIDX_W    = 8;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 4'd0,
    OP_PUSH_BACK  = 4'd1,
    OP_POP_FRONT  = 4'd2,
    OP_POP_BACK   = 4'd3,
    OP_INSERT     = 4'd4,
    OP_ERASE      = 4'd5,
    OP_ERASE_RNG  = 4'd6,
    OP_CLEAR      = 4'd7,
    OP_READ       = 4'd8
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [POS_W-1:0]         position;
    logic [AMT_W-1:0]         amount;
    logic signed [DATA_W-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic [LEN_W-1:0]         length;
    logic [ST_W-1:0]          status;
  } rsp_t;

  // Per-cycle action of the cell row.
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,  // keep content
    CELL_WRITE = 2'd1,  // cell at idx takes the word
    CELL_OPEN  = 2'd2,  // cells past idx take left neighbor, idx takes the word
    CELL_CLOSE = 2'd3   // cells at and past idx take right neighbor
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [CIDX_W-1:0]   idx;
    logic [DATA_W-1:0]   word;
  } cell_cmd_t;

endpackage

/* rtl/iss_cell.sv */
// One storage cell of the sequence row.
// Depends on iss_pkg for the broadcast command; trades words with its neighbors.
`timescale 1ns / 1ps

module iss_cell #(
  parameter int INDEX = 0
) (
  input  logic                      clk,
  input  iss_pkg::cell_cmd_t        cmd,
  input  logic [iss_pkg::DATA_W-1:0] left_word,
  input  logic [iss_pkg::DATA_W-1:0] right_word,
  output logic [iss_pkg::DATA_W-1:0] word
);

  localparam logic [iss_pkg::CIDX_W-1:0] MY_IDX = iss_pkg::CIDX_W'(INDEX);

  logic [iss_pkg::DATA_W-1:0] word_r;
  logic [iss_pkg::DATA_W-1:0] word_nxt;

  // Pick own content, a neighbor's, or the new word
  always_comb begin
    word_nxt = word_r;
    case (cmd.op)
      iss_pkg::CELL_HOLD: begin
        word_nxt = word_r;
      end
      iss_pkg::CELL_WRITE: begin
        if (MY_IDX == cmd.idx) word_nxt = cmd.word;
      end
      iss_pkg::CELL_OPEN: begin
        if (MY_IDX == cmd.idx) word_nxt = cmd.word;
        else if (MY_IDX > cmd.idx) word_nxt = left_word;
      end
      iss_pkg::CELL_CLOSE: begin
        if (MY_IDX >= cmd.idx) word_nxt = right_word;
      end
      default: begin
        word_nxt = word_r;
      end
    endcase
  end

  // Hold content; no reset on payload
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

/* rtl/iss_chain.sv */
// Row of DEPTH storage cells, each linked to its two neighbors.
// Depends on iss_pkg and iss_cell.
`timescale 1ns / 1ps

module iss_chain #(
  parameter int DEPTH = iss_pkg::DEPTH_DEF
) (
  input  logic                                  clk,
  input  iss_pkg::cell_cmd_t                    cmd,
  output logic [DEPTH-1:0][iss_pkg::DATA_W-1:0] words
);

  // Build the row; the ends see zero from outside
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [iss_pkg::DATA_W-1:0] left_w;
    logic [iss_pkg::DATA_W-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_inner_l
      assign left_w = words[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner_r
      assign right_w = words[i+1];
    end

    iss_cell #(
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (words[i])
    );
  end

endmodule

/* rtl/indexed_sequence_store.sv */
// Indexed sequence store: ordered list of up to DEPTH words kept in a cell row.
// Result is registered and valid in the cycle after accept; an erase range removing n > 1
// elements runs one single-step shift of the cell row per cycle and reports when the last is done.
// Throughput: one request per cycle for every other operation while the output is not stalled.
// Reset: occupancy, state and output valid clear; cell contents are not reset.
// Depends on iss_pkg and iss_chain.
`timescale 1ns / 1ps

module indexed_sequence_store #(
  parameter int DEPTH = iss_pkg::DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  iss_pkg::req_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output iss_pkg::rsp_t   out_data
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > iss_pkg::POS_W) ? CNT_W : iss_pkg::POS_W;

  typedef enum logic {
    S_IDLE,
    S_SHIFT
  } state_t;

  state_t                     state_r, state_nxt;
  logic [CNT_W-1:0]           occ_r, occ_nxt;
  logic [CNT_W-1:0]           rem_r, rem_nxt;
  logic [IDX_W-1:0]           pos_r, pos_nxt;
  logic                       out_valid_r, out_valid_nxt;
  iss_pkg::rsp_t              out_data_r, out_data_nxt;

  iss_pkg::cell_cmd_t                    cmd;
  logic [DEPTH-1:0][iss_pkg::DATA_W-1:0] words;

  logic                       in_acc;
  logic                       full;
  logic                       empty;
  logic [CMP_W-1:0]           occ_x, pos_x, amt_x, room, cnt;
  logic [CNT_W-1:0]           acc_occ;
  logic [iss_pkg::ST_W-1:0]   acc_st;
  logic [iss_pkg::DATA_W-1:0] acc_rd;
  logic                       acc_multi;
  iss_pkg::cell_cmd_t         acc_cmd;

  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;

  assign occ_x = CMP_W'(occ_r);
  assign pos_x = CMP_W'(in_data.position);
  assign amt_x = CMP_W'(in_data.amount);
  assign full  = (occ_r == CNT_W'(DEPTH));
  assign empty = (occ_r == '0);
  assign room  = occ_x - pos_x;
  assign cnt   = (amt_x < room) ? amt_x : room;

  // Decode the request against the current occupancy
  always_comb begin
    acc_occ       = occ_r;
    acc_st        = iss_pkg::ST_DONE;
    acc_rd        = '0;
    acc_multi     = 1'b0;
    acc_cmd.op    = iss_pkg::CELL_HOLD;
    acc_cmd.idx   = '0;
    acc_cmd.word  = in_data.data_in;
    case (in_data.op)
      iss_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          acc_st = iss_pkg::ST_FULL;
        end else begin
          acc_cmd.op = iss_pkg::CELL_OPEN;
          acc_occ    = occ_r + 1'b1;
        end
      end
      iss_pkg::OP_PUSH_BACK: begin
        if (full) begin
          acc_st = iss_pkg::ST_FULL;
        end else begin
          acc_cmd.op  = iss_pkg::CELL_WRITE;
          acc_cmd.idx = iss_pkg::CIDX_W'(IDX_W'(occ_r));
          acc_occ     = occ_r + 1'b1;
        end
      end
      iss_pkg::OP_POP_FRONT: begin
        if (empty) begin
          acc_st = iss_pkg::ST_IGNORED;
        end else begin
          acc_cmd.op = iss_pkg::CELL_CLOSE;
          acc_occ    = occ_r - 1'b1;
        end
      end
      iss_pkg::OP_POP_BACK: begin
        if (empty) acc_st = iss_pkg::ST_IGNORED;
        else acc_occ = occ_r - 1'b1;
      end
      iss_pkg::OP_INSERT: begin
        if (pos_x > occ_x) begin
          acc_st = iss_pkg::ST_IGNORED;
        end else if (full) begin
          acc_st = iss_pkg::ST_FULL;
        end else begin
          acc_cmd.op  = iss_pkg::CELL_OPEN;
          acc_cmd.idx = iss_pkg::CIDX_W'(IDX_W'(pos_x));
          acc_occ     = occ_r + 1'b1;
        end
      end
      iss_pkg::OP_ERASE: begin
        if (pos_x >= occ_x) begin
          acc_st = iss_pkg::ST_IGNORED;
        end else begin
          acc_cmd.op  = iss_pkg::CELL_CLOSE;
          acc_cmd.idx = iss_pkg::CIDX_W'(IDX_W'(pos_x));
          acc_occ     = occ_r - 1'b1;
        end
      end
      iss_pkg::OP_ERASE_RNG: begin
        if (pos_x > occ_x) begin
          acc_st = iss_pkg::ST_IGNORED;
        end else begin
          acc_occ = CNT_W'(occ_x - cnt);
          if (cnt != '0) begin
            acc_cmd.op  = iss_pkg::CELL_CLOSE;
            acc_cmd.idx = iss_pkg::CIDX_W'(IDX_W'(pos_x));
          end
          acc_multi = (cnt > CMP_W'(1));
        end
      end
      iss_pkg::OP_CLEAR: begin
        acc_occ = '0;
      end
      iss_pkg::OP_READ: begin
        if (pos_x >= occ_x) acc_st = iss_pkg::ST_IGNORED;
        else acc_rd = words[IDX_W'(pos_x)];
      end
      default: begin
        acc_st = iss_pkg::ST_IGNORED;
      end
    endcase
  end

  // Drive the cell row: accepted request, or one more close step
  always_comb begin
    cmd      = '0;
    cmd.op   = iss_pkg::CELL_HOLD;
    cmd.word = in_data.data_in;
    if (state_r == S_SHIFT) begin
      cmd.op  = iss_pkg::CELL_CLOSE;
      cmd.idx = iss_pkg::CIDX_W'(pos_r);
    end else if (in_acc) begin
      cmd = acc_cmd;
    end
  end

  // Next state, count and result register
  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    rem_nxt       = rem_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          occ_nxt               = acc_occ;
          out_data_nxt.data_out = acc_rd;
          out_data_nxt.length   = iss_pkg::LEN_W'(acc_occ);
          out_data_nxt.status   = acc_st;
          if (acc_multi) begin
            state_nxt     = S_SHIFT;
            rem_nxt       = CNT_W'(cnt - CMP_W'(1));
            pos_nxt       = IDX_W'(pos_x);
            out_valid_nxt = 1'b0;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_SHIFT: begin
        rem_nxt = rem_r - 1'b1;
        if (rem_r == CNT_W'(1)) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r      <= pos_nxt;
    out_data_r <= out_data_nxt;
  end

  iss_chain #(
    .DEPTH (DEPTH)
  ) u_chain (
    .clk   (clk),
    .cmd   (cmd),
    .words (words)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Occupancy never exceeds the row
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(DEPTH))
    else $error("occupancy beyond depth");

  // No result is shown while a range erase is still shifting
  a_shift_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT |-> !out_valid_r)
    else $error("result valid during shift");

  // A flagged request leaves the occupancy alone
  a_flag_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && acc_st != iss_pkg::ST_DONE |=> occ_r == $past(occ_r))
    else $error("flagged request changed occupancy");

  // A refusal is only ever reported on a full store
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status == iss_pkg::ST_FULL |->
      out_data_r.length == iss_pkg::LEN_W'(DEPTH))
    else $error("refused while not full");

  // Nothing is accepted while a shift runs
  a_no_acc_shift: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT |-> !in_acc)
    else $error("request accepted during shift");

endmodule

/* bench/indexed_sequence_store_test.sv */
// Self-checking bench for indexed_sequence_store: a scoreboard class predicts responses.
// Plain tasks drive requests; a receiver process checks each response in order.
// Depends on iss_pkg and the indexed_sequence_store RTL.
`timescale 1ns / 1ps

module indexed_sequence_store_test;

  // Operation code outside the defined set
  localparam logic [iss_pkg::OP_W-1:0] OP_UNKNOWN = 4'd15;

  // Track the stored sequence and queue the responses still owed
  class sequence_scoreboard;
    logic [iss_pkg::DATA_W-1:0] cells [iss_pkg::DEPTH_DEF];
    int unsigned                occupancy;
    iss_pkg::rsp_t              owed_rsp[$];
    int                         errors;
    int                         requests;
    int                         results;
    int                         refused;
    int                         ignored;
    int unsigned                peak_length;

    function new();
      occupancy   = 0;
      errors      = 0;
      requests    = 0;
      results     = 0;
      refused     = 0;
      ignored     = 0;
      peak_length = 0;
    endfunction

    function int pending();
      return owed_rsp.size();
    endfunction

    // Shift pos and everything after it back by one slot, then place the word
    function void open_slot(int unsigned pos, logic [iss_pkg::DATA_W-1:0] word);
      for (int unsigned i = occupancy; i > pos; i--) cells[i] = cells[i - 1];
      cells[pos] = word;
      occupancy++;
    endfunction

    // Remove n elements at pos by moving the tail forward
    function void drop_span(int unsigned pos, int unsigned n);
      for (int unsigned i = pos; i + n < occupancy; i++) cells[i] = cells[i + n];
      occupancy -= n;
    endfunction

    // Apply one accepted request and queue the response it owes
    function void note_request(iss_pkg::req_t r);
      iss_pkg::rsp_t e;
      int unsigned   pos;
      int unsigned   amt;
      e = '0;
      e.status = iss_pkg::ST_DONE;
      pos = 32'(r.position);
      amt = 32'(r.amount);
      case (r.op)
        iss_pkg::OP_PUSH_FRONT: begin
          if (occupancy >= iss_pkg::DEPTH_DEF) e.status = iss_pkg::ST_FULL;
          else open_slot(0, r.data_in);
        end
        iss_pkg::OP_PUSH_BACK: begin
          if (occupancy >= iss_pkg::DEPTH_DEF) e.status = iss_pkg::ST_FULL;
          else open_slot(occupancy, r.data_in);
        end
        iss_pkg::OP_POP_FRONT: begin
          if (occupancy == 0) e.status = iss_pkg::ST_IGNORED;
          else drop_span(0, 1);
        end
        iss_pkg::OP_POP_BACK: begin
          if (occupancy == 0) e.status = iss_pkg::ST_IGNORED;
          else occupancy--;
        end
        iss_pkg::OP_INSERT: begin
          // The range check wins over the full check
          if (pos > occupancy) e.status = iss_pkg::ST_IGNORED;
          else if (occupancy >= iss_pkg::DEPTH_DEF) e.status = iss_pkg::ST_FULL;
          else open_slot(pos, r.data_in);
        end
        iss_pkg::OP_ERASE: begin
          if (pos >= occupancy) e.status = iss_pkg::ST_IGNORED;
          else drop_span(pos, 1);
        end
        iss_pkg::OP_ERASE_RNG: begin
          if (pos > occupancy) e.status = iss_pkg::ST_IGNORED;
          else drop_span(pos, (amt < occupancy - pos) ? amt : occupancy - pos);
        end
        iss_pkg::OP_CLEAR: occupancy = 0;
        iss_pkg::OP_READ: begin
          if (pos >= occupancy) e.status = iss_pkg::ST_IGNORED;
          else e.data_out = cells[pos];
        end
        default: e.status = iss_pkg::ST_IGNORED;
      endcase
      e.length = iss_pkg::LEN_W'(occupancy);
      owed_rsp = {owed_rsp, e};
      requests++;
      if (e.status == iss_pkg::ST_FULL) refused++;
      if (e.status == iss_pkg::ST_IGNORED) ignored++;
      if (occupancy > peak_length) peak_length = occupancy;
    endfunction

    // Compare one accepted response with the oldest one owed
    function void check_result(iss_pkg::rsp_t got);
      iss_pkg::rsp_t e;
      results++;
      if (owed_rsp.size() == 0) begin
        $error("unexpected response: data_out %0d length %0d status %0d",
               got.data_out, got.length, got.status);
        errors++;
        return;
      end
      e = owed_rsp[0];
      owed_rsp.delete(0);
      if (got.data_out !== e.data_out) begin
        $error("data_out mismatch: expected %0d, got %0d", e.data_out, got.data_out);
        errors++;
      end
      if (got.length !== e.length) begin
        $error("length mismatch: expected %0d, got %0d", e.length, got.length);
        errors++;
      end
      if (got.status !== e.status) begin
        $error("status mismatch: expected %0d, got %0d", e.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  iss_pkg::req_t  in_data;
  logic           out_valid;
  logic           out_stall;
  iss_pkg::rsp_t  out_data;

  sequence_scoreboard board;
  int stall_pct;
  int hold_left;

  indexed_sequence_store dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Free-running clock, 2 ns period
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the handshake hangs
  initial begin
    #2_000_000;
    $display("indexed_sequence_store_test failed");
    $finish;
  end

  // Check responses; stall at random or hold off for a counted stretch
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (out_valid && !out_stall) board.check_result(out_data);
        if (hold_left > 0) begin
          out_stall <= 1'b1;
          hold_left--;
        end else begin
          out_stall <= ($urandom_range(99) < stall_pct);
        end
      end
    end
  end

  function automatic iss_pkg::req_t make_request(logic [iss_pkg::OP_W-1:0] op, int pos,
                                                 int amt, logic [iss_pkg::DATA_W-1:0] word);
    iss_pkg::req_t r;
    r.op       = op;
    r.position = iss_pkg::POS_W'(pos);
    r.amount   = iss_pkg::AMT_W'(amt);
    r.data_in  = word;
    return r;
  endfunction

  // Pick a request, mostly well aimed at the current length, growing or shrinking the store
  function automatic iss_pkg::req_t random_request(bit grow);
    iss_pkg::req_t r;
    int unsigned   occ;
    int            pick;
    occ = board.occupancy;
    pick = $urandom_range(99);
    r.data_in = $urandom;
    r.amount = ($urandom_range(3) == 0) ? iss_pkg::AMT_W'($urandom_range(31))
                                        : iss_pkg::AMT_W'($urandom_range(4));
    r.position = ($urandom_range(4) == 0) ? iss_pkg::POS_W'($urandom_range(31))
                                          : iss_pkg::POS_W'($urandom_range(occ));
    if (pick < 3) begin
      r.op = iss_pkg::OP_W'($urandom_range(15, 9));
    end else if (pick < 5) begin
      r.op = iss_pkg::OP_CLEAR;
    end else if (pick < 25) begin
      r.op = iss_pkg::OP_READ;
    end else if (pick < (grow ? 75 : 45)) begin
      case ($urandom_range(2))
        0: r.op = iss_pkg::OP_PUSH_FRONT;
        1: r.op = iss_pkg::OP_PUSH_BACK;
        default: r.op = iss_pkg::OP_INSERT;
      endcase
    end else begin
      case ($urandom_range(3))
        0: r.op = iss_pkg::OP_POP_FRONT;
        1: r.op = iss_pkg::OP_POP_BACK;
        2: r.op = iss_pkg::OP_ERASE;
        default: r.op = iss_pkg::OP_ERASE_RNG;
      endcase
    end
    return r;
  endfunction

  // Offer one request after a random idle gap and wait until it is taken
  task automatic send_request(iss_pkg::req_t r, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    board.note_request(r);
  endtask

  // Drop valid and hold until every owed response has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic run_phase(int idle_pct, int stall, int count);
    stall_pct = stall;
    for (int i = 0; i < count; i++) send_request(random_request((i / 20) % 2 == 0), idle_pct);
  endtask

  initial begin
    iss_pkg::req_t directed[$];
    board     = new();
    stall_pct = 0;
    hold_left = 0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty store: pops, erases and reads are flagged; a zero-length range erase is done
    directed = {directed, make_request(iss_pkg::OP_POP_FRONT, 0, 0, 0)};
    directed = {directed, make_request(iss_pkg::OP_POP_BACK, 0, 0, 0)};
    directed = {directed, make_request(iss_pkg::OP_ERASE, 0, 0, 0)};
    directed = {directed, make_request(iss_pkg::OP_ERASE_RNG, 0, 3, 0)};
    directed = {directed, make_request(iss_pkg::OP_READ, 0, 0, 0)};
    directed = {directed, make_request(iss_pkg::OP_INSERT, 1, 0, 32'h1234_5678)};
    // Extreme words at both ends
    directed = {directed, make_request(iss_pkg::OP_INSERT, 0, 0, 32'h8000_0000)};
    directed = {directed, make_request(iss_pkg::OP_PUSH_BACK, 0, 0, 32'h7fff_ffff)};
    directed = {directed, make_request(iss_pkg::OP_PUSH_FRONT, 0, 0, 32'hffff_ffff)};
    directed = {directed, make_request(iss_pkg::OP_READ, 31, 31, 0)};
    // Fill to the top, then refuse further growth
    for (int i = 0; i < iss_pkg::DEPTH_DEF - 3; i++)
      directed = {directed, make_request(iss_pkg::OP_PUSH_BACK, 0, 0, 32'(32'h100 + i))};
    directed = {directed, make_request(iss_pkg::OP_PUSH_FRONT, 0, 0, 32'h5555_aaaa)};
    directed = {directed, make_request(iss_pkg::OP_INSERT, 16, 0, 32'h0)};
    directed = {directed, make_request(iss_pkg::OP_INSERT, 17, 0, 32'h0)};
    directed = {directed, make_request(iss_pkg::OP_READ, 15, 0, 0)};
    // Shrink: erase the last slot, a wide range, an empty range at the end
    directed = {directed, make_request(iss_pkg::OP_ERASE, 15, 0, 0)};
    directed = {directed, make_request(iss_pkg::OP_ERASE_RNG, 2, 31, 0)};
    directed = {directed, make_request(iss_pkg::OP_ERASE_RNG, 2, 5, 0)};
    directed = {directed, make_request(OP_UNKNOWN, 0, 0, 0)};
    directed = {directed, make_request(iss_pkg::OP_CLEAR, 0, 0, 0)};
    foreach (directed[i]) send_request(directed[i], 0);
    drain();

    // Random traffic across the idle and stall mixes
    run_phase(0, 0, 100);
    run_phase(74, 0, 100);

    // Hold the receiver off while requests keep coming, so the block backs up
    stall_pct = 0;
    hold_left = 60;
    for (int i = 0; i < 40; i++) send_request(random_request(1'b1), 0);
    drain();

    run_phase(0, 74, 100);
    run_phase(25, 25, 100);
    run_phase(0, 0, 60);

    // Let the last responses land, then look for strays
    drain();
    stall_pct = 0;
    repeat (40) @(posedge clk);

    $display("Checked %0d requests and %0d responses: %0d refused full, %0d ignored",
             board.requests, board.results, board.refused, board.ignored);
    $display("Store reached a peak length of %0d under mixed idle and stall patterns",
             board.peak_length);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("indexed_sequence_store_test passed");
    end else begin
      $display("indexed_sequence_store_test failed");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/iss_pkg.sv
rtl/iss_cell.sv
rtl/iss_chain.sv
rtl/indexed_sequence_store.sv
bench/indexed_sequence_store_test.sv
